FILE: rtl/moore_rule_table_automaton_step_assert.svh
// Assertion macros shared by the checker.
`ifndef MOORE_RULE_TABLE_AUTOMATON_STEP_ASSERT_SVH
`define MOORE_RULE_TABLE_AUTOMATON_STEP_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define MRTA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mrta assertion failed");

// Next-cycle implication, off while reset is held.
`define MRTA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mrta assertion failed");

// Next-cycle implication that also watches reset itself.
`define MRTA_ASSERT_RST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("mrta assertion failed");

`endif

FILE: rtl/mrta_pkg.sv
package mrta_pkg;

    localparam int GRID_SIZE      = 64;
    localparam int ROW_W          = 64;
    localparam int IDX_W          = 6;
    localparam int CFG_IDX_W      = 4;
    localparam int NUM_RULE_WORDS = 8;
    localparam int RULE_SEL_W     = $clog2(NUM_RULE_WORDS);
    localparam int RULE_BITS      = NUM_RULE_WORDS * ROW_W;
    localparam int NBR_W          = 9;
    localparam int ROW_AW         = $clog2(GRID_SIZE);
    localparam int CNT_W          = $clog2(GRID_SIZE + 3);

    localparam logic [ROW_W-1:0] ROW_MASK = {ROW_W{1'b1}} >> (ROW_W - GRID_SIZE);

    // Step sequence points of the row counter.
    localparam logic [CNT_W-1:0] CNT_SAVE_ROW0 = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_FIRST_ROW = CNT_W'(3);
    localparam logic [CNT_W-1:0] CNT_LAST_READ = CNT_W'(GRID_SIZE);
    localparam logic [CNT_W-1:0] CNT_LAST     = CNT_W'(GRID_SIZE + 2);

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    typedef enum logic {
        S_IDLE,
        S_STEP
    } t_state;

    typedef struct packed {
        logic             action;
        logic [IDX_W-1:0] row_index;
        logic [ROW_W-1:0] row_cells;
    } t_in_req;

    typedef struct packed {
        logic [IDX_W-1:0] out_row_index;
        logic [ROW_W-1:0] out_row_cells;
        logic             last_row;
    } t_out_rsp;

    typedef struct packed {
        logic              load;
        logic              rd_en;
        logic [ROW_AW-1:0] rd_addr;
        logic              shift;
        logic              save_row0;
        logic              compute;
        logic              last;
        logic [IDX_W-1:0]  row;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/mrta_ram.sv
module mrta_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/mrta_ctrl.sv
module mrta_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_action,
    output logic            o_in_stall,
    input  mrta_pkg::t_sts  i_sts,
    output mrta_pkg::t_cmd  o_cmd
);

    mrta_pkg::t_state                r_state, n_state;
    logic [mrta_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic                            adv;

    assign adv = i_sts.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrta_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mrta_pkg::S_IDLE: begin
                if (i_in_valid && i_in_action == mrta_pkg::ACT_STEP) begin
                    n_state = mrta_pkg::S_STEP;
                end
            end
            mrta_pkg::S_STEP: begin
                if (adv && r_cnt == mrta_pkg::CNT_LAST) begin
                    n_state = mrta_pkg::S_IDLE;
                end
            end
            default: n_state = mrta_pkg::S_IDLE;
        endcase
    end

    // Row counter: advance only when the output register can take a row.
    always_comb begin
        n_cnt = r_cnt;
        if (r_state != mrta_pkg::S_STEP) begin
            n_cnt = '0;
        end else if (adv) begin
            n_cnt = (r_cnt == mrta_pkg::CNT_LAST) ? '0 : r_cnt + mrta_pkg::CNT_W'(1);
        end
    end

    // Outputs.
    always_comb begin
        o_in_stall      = 1'b1;
        o_cmd           = '0;
        o_cmd.rd_addr   = (r_cnt == '0) ? mrta_pkg::ROW_AW'(mrta_pkg::GRID_SIZE - 1)
                                        : mrta_pkg::ROW_AW'(r_cnt - mrta_pkg::CNT_W'(1));
        o_cmd.row       = mrta_pkg::IDX_W'(r_cnt - mrta_pkg::CNT_FIRST_ROW);
        case (r_state)
            mrta_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid && i_in_action == mrta_pkg::ACT_LOAD;
            end
            mrta_pkg::S_STEP: begin
                o_cmd.rd_en     = adv && r_cnt <= mrta_pkg::CNT_LAST_READ;
                o_cmd.shift     = adv && r_cnt != '0;
                o_cmd.save_row0 = adv && r_cnt == mrta_pkg::CNT_SAVE_ROW0;
                o_cmd.compute   = adv && r_cnt >= mrta_pkg::CNT_FIRST_ROW;
                o_cmd.last      = r_cnt == mrta_pkg::CNT_LAST;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/mrta_datapath.sv
module mrta_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [mrta_pkg::IDX_W-1:0]       i_row_index,
    input  logic [mrta_pkg::ROW_W-1:0]       i_row_cells,
    input  logic                             i_cfg_we,
    input  logic [mrta_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mrta_pkg::ROW_W-1:0]       i_cfg_data,
    input  mrta_pkg::t_cmd                   i_cmd,
    output mrta_pkg::t_sts                   o_sts,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output mrta_pkg::t_out_rsp               o_out_rsp
);

    logic [mrta_pkg::NUM_RULE_WORDS-1:0][mrta_pkg::ROW_W-1:0] r_rule;
    logic [mrta_pkg::RULE_BITS-1:0]  rule_flat;
    logic [mrta_pkg::GRID_SIZE-1:0]  r_vld;
    logic                            r_rd_vld;
    logic [mrta_pkg::ROW_W-1:0]      r_up, r_mid, r_row0;
    logic [mrta_pkg::ROW_W-1:0]      ram_rd, rd_row, dn_row, new_row;
    logic                            wr_en, load_ok;
    logic [mrta_pkg::ROW_AW-1:0]     wr_addr;
    logic [mrta_pkg::ROW_W-1:0]      wr_data;
    logic                            r_out_vld;
    mrta_pkg::t_out_rsp              r_out;

    assign rule_flat = r_rule;

    // Rule registers; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule <= '0;
        end else if (i_cfg_we && i_cfg_index < mrta_pkg::CFG_IDX_W'(mrta_pkg::NUM_RULE_WORDS)) begin
            r_rule[i_cfg_index[mrta_pkg::RULE_SEL_W-1:0]] <= i_cfg_data;
        end
    end

    assign load_ok = {1'b0, i_row_index} < (mrta_pkg::IDX_W+1)'(mrta_pkg::GRID_SIZE);
    assign wr_en   = (i_cmd.load && load_ok) || i_cmd.compute;
    assign wr_addr = i_cmd.load ? i_row_index[mrta_pkg::ROW_AW-1:0]
                                : i_cmd.row[mrta_pkg::ROW_AW-1:0];
    assign wr_data = i_cmd.load ? (i_row_cells & mrta_pkg::ROW_MASK) : new_row;

    mrta_ram #(
        .WIDTH (mrta_pkg::ROW_W),
        .DEPTH (mrta_pkg::GRID_SIZE)
    ) u_grid (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_cmd.rd_addr),
        .o_rd_data (ram_rd)
    );

    // Rows never written read as dead.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_vld <= r_vld[i_cmd.rd_addr];
            end
        end
    end

    assign rd_row = r_rd_vld ? ram_rd : '0;
    assign dn_row = i_cmd.last ? r_row0 : rd_row;

    // Three-row window over the old generation.
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_up  <= r_mid;
            r_mid <= rd_row;
        end
        if (i_cmd.save_row0) begin
            r_row0 <= rd_row;
        end
    end

    for (genvar c = 0; c < mrta_pkg::ROW_W; c++) begin : g_cell
        if (c < mrta_pkg::GRID_SIZE) begin : g_live
            localparam int LF = (c + mrta_pkg::GRID_SIZE - 1) % mrta_pkg::GRID_SIZE;
            localparam int RT = (c + 1) % mrta_pkg::GRID_SIZE;
            logic [mrta_pkg::NBR_W-1:0] nbr;
            assign nbr = {r_up[LF],   r_up[c],   r_up[RT],
                          r_mid[LF],  r_mid[c],  r_mid[RT],
                          dn_row[LF], dn_row[c], dn_row[RT]};
            assign new_row[c] = rule_flat[nbr];
        end else begin : g_dead
            assign new_row[c] = 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.compute) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.compute) begin
            r_out.out_row_index <= i_cmd.row;
            r_out.out_row_cells <= new_row;
            r_out.last_row      <= i_cmd.last;
        end
    end

    assign o_sts.out_free = !r_out_vld || !i_out_stall;
    assign o_out_valid    = r_out_vld;
    assign o_out_rsp      = r_out;

endmodule

FILE: rtl/moore_rule_table_automaton_step.sv
// Binary 2-D automaton on a wrapping 64x64 grid with a 512-entry 3x3 rule table.
// Request channel (i_in_valid / o_in_stall, i_in_req): a load request writes one
// row of cells and gives no result; a step request computes one generation and
// returns one result per grid row, row 0 first, last_row set on the final row.
// Result channel (o_out_valid / i_out_stall, o_out_rsp) comes from an output
// register, which holds a waiting result until the receiver takes it.
// Rule words arrive on i_cfg_valid / o_cfg_ready; write them only while idle.
// A load writes its row when taken while idle. A step request is taken while idle,
// then the request channel stalls while the single grid RAM read port streams one
// old row per cycle, while the output register can take a row, through a
// three-row window; three rows fill that window, then one result per row follows.
// A stalled receiver freezes the whole step sequence (RAM reads, window,
// write-back) until the output register drains; results stay in order.
// o_in_stall is high for the whole step. Reset clears the rule words and the
// row valid bits, so the grid reads as all dead; no clearing pass is needed.
module moore_rule_table_automaton_step (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  mrta_pkg::t_in_req               i_in_req,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output mrta_pkg::t_out_rsp              o_out_rsp,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mrta_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mrta_pkg::ROW_W-1:0]      i_cfg_data
);

    mrta_pkg::t_cmd cmd;
    mrta_pkg::t_sts sts;

    // Rule words are plain registers; always take the write.
    assign o_cfg_ready = 1'b1;

    // Sequence loads and the row-by-row step.
    mrta_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_action (i_in_req.action),
        .o_in_stall  (o_in_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Grid RAM, row window, rule lookup and output register.
    mrta_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_row_index (i_in_req.row_index),
        .i_row_cells (i_in_req.row_cells),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

endmodule

FILE: rtl/mrta_checker.sv
`include "moore_rule_table_automaton_step_assert.svh"

module mrta_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               o_in_stall,
    input  mrta_pkg::t_in_req  i_in_req,
    input  logic               o_out_valid,
    input  logic               i_out_stall,
    input  mrta_pkg::t_out_rsp o_out_rsp
);

    // No result survives reset.
    `MRTA_ASSERT_RST_NEXT(a_rst_clears_out, !i_rst_n, !o_out_valid)

    // A held result keeps its payload.
    `MRTA_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
                      o_out_valid && $stable(o_out_rsp))

    // A step request keeps the block busy.
    `MRTA_ASSERT_NEXT(a_step_busy,
                      i_in_valid && !o_in_stall && i_in_req.action == mrta_pkg::ACT_STEP,
                      o_in_stall)

    // Until the final row is out, the step is still running.
    `MRTA_ASSERT_NOW(a_mid_step_busy, o_out_valid && !o_out_rsp.last_row, o_in_stall)

endmodule

bind moore_rule_table_automaton_step mrta_checker u_checker (.*);
